// ===== hw/rtl/patch_valid_point_median_core_assert.svh =====
// assertion macros for the patch median core
`ifndef PATCH_VALID_POINT_MEDIAN_CORE_ASSERT_SVH
`define PATCH_VALID_POINT_MEDIAN_CORE_ASSERT_SVH

// clocked property check, quiet while reset is high
`define PVPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also runs during reset
`define PVPM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/pvpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pvpm_pkg
// shared constants, state and command types of the patch median core
// ----------------------------------------------------------------------------
package pvpm_pkg;

   localparam int PATCH_RADIUS_DEF = 2;
   localparam int COORD_BITS_DEF   = 20;
   localparam int MIN_BITS         = 5;
   localparam int COUNT_OUT_BITS   = 5;
   localparam logic [MIN_BITS-1:0] MIN_RESET = 5'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK,
      ST_LOAD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic                      store;
      logic                      clear;
      logic                      compare;
      logic                      check;
      logic                      load;
      logic                      found;
      logic [COUNT_OUT_BITS-1:0] count;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic point_valid;
      logic rsp_busy;
   } status_type;

endpackage

// ===== hw/rtl/pvpm_if.sv =====
// ----------------------------------------------------------------------------
// pvpm_if
// valid/ready channels: point items, result items, register writes
// ----------------------------------------------------------------------------
interface pvpm_req_if #(parameter int COORD_BITS = pvpm_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic                         patch_end;
   modport source (output valid, point_x, point_y, point_z, patch_end, input ready);
   modport sink (input valid, point_x, point_y, point_z, patch_end, output ready);
   modport monitor (input valid, ready, point_x, point_y, point_z, patch_end);
endinterface

interface pvpm_rsp_if #(parameter int COORD_BITS = pvpm_pkg::COORD_BITS_DEF);
   logic                                        valid;
   logic                                        ready;
   logic                                        found;
   logic signed [COORD_BITS:0]                  median_x;
   logic signed [COORD_BITS:0]                  median_y;
   logic signed [COORD_BITS:0]                  median_z;
   logic [pvpm_pkg::COUNT_OUT_BITS-1:0]         valid_count;
   modport source (output valid, found, median_x, median_y, median_z, valid_count,
                   input ready);
   modport sink (input valid, found, median_x, median_y, median_z, valid_count,
                 output ready);
   modport monitor (input valid, ready, found, median_x, median_y, median_z,
                    valid_count);
endinterface

interface pvpm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pvpm_pkg::MIN_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
   modport monitor (input valid, ready, data);
endinterface

// ===== hw/rtl/pvpm_ram.sv =====
// ----------------------------------------------------------------------------
// pvpm_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module pvpm_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 25,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr_a,
   output logic [WIDTH-1:0] rdata_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// ===== hw/rtl/pvpm_lane.sv =====
// ----------------------------------------------------------------------------
// pvpm_lane
// one axis: value store and rank count selection of the two middle values
// ----------------------------------------------------------------------------
module pvpm_lane #(
   parameter int COORD_BITS = pvpm_pkg::COORD_BITS_DEF,
   parameter int DEPTH = 25,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  pvpm_pkg::cmd_type            cmd,
   input  logic [AW-1:0]                wr_addr,
   input  logic signed [COORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]                addr_a,
   input  logic [AW-1:0]                addr_b,
   input  logic [CW-1:0]                k_lo,
   input  logic [CW-1:0]                k_hi,
   output logic signed [COORD_BITS:0]   median
);

   logic [COORD_BITS-1:0]        cand_raw;
   logic [COORD_BITS-1:0]        cmp_raw;
   logic signed [COORD_BITS-1:0] cand;
   logic signed [COORD_BITS-1:0] cmp;
   logic [CW-1:0]                lt_ff, lt_in;
   logic [CW-1:0]                eq_ff, eq_in;
   logic signed [COORD_BITS-1:0] lo_ff, lo_in;
   logic signed [COORD_BITS-1:0] hi_ff, hi_in;
   logic [CW:0]                  upper;

   pvpm_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .we      (cmd.store),
      .waddr   (wr_addr),
      .wdata   (wr_data),
      .raddr_a (addr_a),
      .rdata_a (cand_raw),
      .raddr_b (addr_b),
      .rdata_b (cmp_raw)
   );

   assign cand  = $signed(cand_raw);
   assign cmp   = $signed(cmp_raw);
   assign upper = {1'b0, lt_ff} + {1'b0, eq_ff};

   // rank counters and middle value capture
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.clear) begin
         lt_in = '0;
         eq_in = '0;
      end else if (cmd.compare) begin
         lt_in = lt_ff + CW'(cmp < cand);
         eq_in = eq_ff + CW'(cmp == cand);
      end
      if (cmd.check) begin
         if ((lt_ff <= k_lo) && ({1'b0, k_lo} < upper)) begin
            lo_in = cand;
         end
         if ((lt_ff <= k_hi) && ({1'b0, k_hi} < upper)) begin
            hi_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      lt_ff <= lt_in;
      eq_ff <= eq_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // half-unit median: sum of the two middle values
   assign median = {lo_ff[COORD_BITS-1], lo_ff} + {hi_ff[COORD_BITS-1], hi_ff};

endmodule

// ===== hw/rtl/pvpm_datapath.sv =====
// ----------------------------------------------------------------------------
// pvpm_datapath
// three axis lanes, point check and result register
// ----------------------------------------------------------------------------
module pvpm_datapath #(
   parameter int COORD_BITS = pvpm_pkg::COORD_BITS_DEF,
   parameter int DEPTH = 25,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pvpm_pkg::cmd_type            cmd,
   output pvpm_pkg::status_type         status,
   input  logic [AW-1:0]                wr_addr,
   input  logic [AW-1:0]                addr_a,
   input  logic [AW-1:0]                addr_b,
   input  logic [CW-1:0]                k_lo,
   input  logic [CW-1:0]                k_hi,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] point_z,
   pvpm_rsp_if.source                   rsp
);

   logic signed [COORD_BITS:0]             med_x, med_y, med_z;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   found_ff;
   logic signed [COORD_BITS:0]             mx_ff, my_ff, mz_ff;
   logic [pvpm_pkg::COUNT_OUT_BITS-1:0]    count_ff;

   pvpm_lane #(.COORD_BITS(COORD_BITS), .DEPTH(DEPTH)) u_lane_x (
      .clock (clock), .cmd (cmd), .wr_addr (wr_addr), .wr_data (point_x),
      .addr_a (addr_a), .addr_b (addr_b), .k_lo (k_lo), .k_hi (k_hi), .median (med_x)
   );
   pvpm_lane #(.COORD_BITS(COORD_BITS), .DEPTH(DEPTH)) u_lane_y (
      .clock (clock), .cmd (cmd), .wr_addr (wr_addr), .wr_data (point_y),
      .addr_a (addr_a), .addr_b (addr_b), .k_lo (k_lo), .k_hi (k_hi), .median (med_y)
   );
   pvpm_lane #(.COORD_BITS(COORD_BITS), .DEPTH(DEPTH)) u_lane_z (
      .clock (clock), .cmd (cmd), .wr_addr (wr_addr), .wr_data (point_z),
      .addr_a (addr_a), .addr_b (addr_b), .k_lo (k_lo), .k_hi (k_hi), .median (med_z)
   );

   // status toward the controller
   assign status.point_valid = (point_z > 0);
   assign status.rsp_busy    = rsp_valid_ff && !rsp.ready;

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff <= cmd.found;
         mx_ff    <= cmd.found ? med_x : '0;
         my_ff    <= cmd.found ? med_y : '0;
         mz_ff    <= cmd.found ? med_z : '0;
         count_ff <= cmd.count;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = found_ff;
   assign rsp.median_x    = mx_ff;
   assign rsp.median_y    = my_ff;
   assign rsp.median_z    = mz_ff;
   assign rsp.valid_count = count_ff;

endmodule

// ===== hw/rtl/pvpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvpm_ctrl
// sequencer: point loading, rank scan over the stored values, result hand-off
// ----------------------------------------------------------------------------
module pvpm_ctrl #(
   parameter int DEPTH = 25,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1),
   localparam int NW = (CW > pvpm_pkg::MIN_BITS) ? CW : pvpm_pkg::MIN_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 patch_end,
   pvpm_csr_if.sink             csr,
   output pvpm_pkg::cmd_type    cmd,
   input  pvpm_pkg::status_type status,
   output logic [AW-1:0]        wr_addr,
   output logic [AW-1:0]        addr_a,
   output logic [AW-1:0]        addr_b,
   output logic [CW-1:0]        k_lo,
   output logic [CW-1:0]        k_hi
);

   pvpm_pkg::state_type           state_ff, state_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 i_ff, i_in;
   logic [CW-1:0]                 j_ff, j_in;
   logic                          found_ff, found_in;
   logic                          cmp_ff, cmp_in;
   logic [pvpm_pkg::MIN_BITS-1:0] min_ff;
   logic [NW-1:0]                 need;
   logic [CW-1:0]                 last_idx;
   logic                          accept;
   logic [NW-1:0]                 cnt_wide;

   assign accept   = req_valid && req_ready;
   assign need     = (min_ff == '0) ? NW'(1) : NW'(min_ff);
   assign last_idx = cnt_ff - CW'(1);
   assign cnt_wide = NW'(cnt_ff);

   // register write port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= pvpm_pkg::MIN_RESET;
      end else if (csr.valid) begin
         min_ff <= csr.data;
      end
   end

   // addresses and ranks
   assign wr_addr = cnt_ff[AW-1:0];
   assign addr_a  = i_ff[AW-1:0];
   assign addr_b  = j_ff[AW-1:0];
   assign k_lo    = last_idx >> 1;
   assign k_hi    = cnt_ff >> 1;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      found_in    = found_ff;
      cmp_in      = 1'b0;
      req_ready   = 1'b0;
      cmd.store   = 1'b0;
      cmd.clear   = 1'b0;
      cmd.compare = cmp_ff;
      cmd.check   = 1'b0;
      cmd.load    = 1'b0;
      cmd.found   = found_ff;
      cmd.count   = cnt_wide[pvpm_pkg::COUNT_OUT_BITS-1:0];
      case (state_ff)
         pvpm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (status.point_valid && (cnt_ff < CW'(DEPTH))) begin
                  cmd.store = 1'b1;
                  cnt_in    = cnt_ff + CW'(1);
               end
               if (patch_end) begin
                  state_in = pvpm_pkg::ST_EVAL;
               end
            end
         end
         pvpm_pkg::ST_EVAL: begin
            found_in = (cnt_wide >= need);
            i_in     = '0;
            state_in = (cnt_wide >= need) ? pvpm_pkg::ST_PREP : pvpm_pkg::ST_LOAD;
         end
         pvpm_pkg::ST_PREP: begin
            cmd.clear = 1'b1;
            j_in      = '0;
            state_in  = pvpm_pkg::ST_SCAN;
         end
         pvpm_pkg::ST_SCAN: begin
            cmp_in = 1'b1;
            j_in   = j_ff + CW'(1);
            if (j_ff == last_idx) begin
               state_in = pvpm_pkg::ST_DRAIN;
            end
         end
         pvpm_pkg::ST_DRAIN: begin
            state_in = pvpm_pkg::ST_CHECK;
         end
         pvpm_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            i_in      = i_ff + CW'(1);
            state_in  = (i_ff == last_idx) ? pvpm_pkg::ST_LOAD : pvpm_pkg::ST_PREP;
         end
         pvpm_pkg::ST_LOAD: begin
            if (!status.rsp_busy) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = pvpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pvpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvpm_pkg::ST_IDLE;
         cnt_ff   <= '0;
         cmp_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cmp_ff   <= cmp_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
   end

`include "patch_valid_point_median_core_assert.svh"

   `PVPM_ASSERT(a_store_idle, cmd.store |-> (state_ff == pvpm_pkg::ST_IDLE), "store outside idle")
   `PVPM_ASSERT(a_cnt_range, cnt_ff <= CW'(DEPTH), "valid count beyond depth")
   `PVPM_ASSERT(a_load_clears, cmd.load |=> (cnt_ff == '0), "count not cleared after load")
   `PVPM_ASSERT(a_scan_found, (state_ff == pvpm_pkg::ST_SCAN) |-> found_ff, "scan without found")
   `PVPM_ASSERT_ALWAYS(a_csr_ready, csr.ready, "register port not ready")

endmodule

// ===== hw/rtl/patch_valid_point_median_core.sv =====
// ----------------------------------------------------------------------------
// patch_valid_point_median_core
// per-axis median of the valid points of one depth patch
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   point_x, point_y, point_z, patch_end
// rsp      out  found, median_x, median_y, median_z, valid_count
// csr      in   min_valid_points (5 bits), always ready
//
// point items are taken back to back while idle; a patch end item goes
// through evaluation and, when its valid points meet the minimum, through
// the rank scan over the dual-read store of each axis, to the result load
// reset is synchronous; min_valid_points resets to 8, the stores need none
// points of the next patch are taken while a result still waits in rsp;
// a stalled rsp holds only the hand-off of the following result
// ----------------------------------------------------------------------------
module patch_valid_point_median_core #(
   parameter int PATCH_RADIUS = pvpm_pkg::PATCH_RADIUS_DEF,
   parameter int COORD_BITS   = pvpm_pkg::COORD_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   pvpm_req_if.sink    req,
   pvpm_rsp_if.source  rsp,
   pvpm_csr_if.sink    csr
);

   localparam int SIDE  = 2 * PATCH_RADIUS + 1;
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   pvpm_pkg::cmd_type    cmd;
   pvpm_pkg::status_type status;
   logic [AW-1:0]        wr_addr, addr_a, addr_b;
   logic [CW-1:0]        k_lo, k_hi;

   pvpm_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .patch_end (req.patch_end),
      .csr       (csr),
      .cmd       (cmd),
      .status    (status),
      .wr_addr   (wr_addr),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .k_lo      (k_lo),
      .k_hi      (k_hi)
   );

   pvpm_datapath #(.COORD_BITS(COORD_BITS), .DEPTH(DEPTH)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .wr_addr (wr_addr),
      .addr_a  (addr_a),
      .addr_b  (addr_b),
      .k_lo    (k_lo),
      .k_hi    (k_hi),
      .point_x (req.point_x),
      .point_y (req.point_y),
      .point_z (req.point_z),
      .rsp     (rsp)
   );

endmodule
